@@ rtl/varint_field_decoder_unit_macros.svh @@
// Assertion macros used by the checker file of the decoder
`ifndef VARINT_FIELD_DECODER_UNIT_MACROS_SVH
`define VARINT_FIELD_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define VFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfd assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define VFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfd assertion failed");

`endif

@@ rtl/vfd_pkg.sv @@
`default_nettype none

package vfd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned MagW   = 61;
    localparam int unsigned ValueW = 62;
    localparam int unsigned LeftW  = 3;
    localparam int unsigned FmtW   = 3;

    // Encoding formats; the remaining codes decode as u64
    typedef enum logic [FmtW-1:0] {
        FMT_U16 = 3'd0,
        FMT_S16 = 3'd1,
        FMT_U32 = 3'd2,
        FMT_S32 = 3'd3,
        FMT_U64 = 3'd4
    } value_format_t;

    localparam value_format_t FormatReset = FMT_U16;

    localparam logic [ByteW-1:0] Bit7Mask  = 8'h80;
    localparam logic [ByteW-1:0] Low7Mask  = 8'h7F;
    localparam logic [ByteW-1:0] Bit6Mask  = 8'h40;
    localparam logic [ByteW-1:0] Low6Mask  = 8'h3F;
    localparam logic [ByteW-1:0] Bit5Mask  = 8'h20;
    localparam logic [ByteW-1:0] Low5Mask  = 8'h1F;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             buffer_end;
    } byte_word_t;

    typedef struct packed {
        logic signed [ValueW-1:0] decoded_value;
        logic                     decode_status;
    } result_word_t;

    // Status codes
    localparam logic StatusComplete  = 1'b0;
    localparam logic StatusTruncated = 1'b1;

    // Decode stage to result register
    typedef struct packed {
        logic         has_result;
        result_word_t word;
    } decode_out_t;

endpackage

`default_nettype wire

@@ rtl/vfd_in_stage.sv @@
`default_nettype none

module vfd_in_stage (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 byte_valid,
    output logic                byte_ready,
    input  vfd_pkg::byte_word_t byte_word,
    input  wire                 slot_free,
    output logic                step,
    output vfd_pkg::byte_word_t held_word
);
    import vfd_pkg::*;

    logic       held_valid_reg;
    logic       held_valid_next;
    byte_word_t held_word_reg;
    logic       load;

    // Take a word whenever the stage is empty or drains this cycle
    assign byte_ready = !held_valid_reg || slot_free;
    assign load       = byte_valid && byte_ready;
    assign step       = held_valid_reg && slot_free;
    assign held_word  = held_word_reg;

    always_comb
    begin
        if (load)
            held_valid_next = 1'b1;
        else if (slot_free)
            held_valid_next = 1'b0;
        else
            held_valid_next = held_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_valid_reg <= 1'b0;
        else
            held_valid_reg <= held_valid_next;
    end

    // Hold the payload until the decode stage consumes it
    always_ff @(posedge clk)
    begin
        if (load)
            held_word_reg <= byte_word;
    end

endmodule

`default_nettype wire

@@ rtl/vfd_decode_core.sv @@
`default_nettype none

module vfd_decode_core (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [vfd_pkg::FmtW-1:0]     cfg_data,
    input  wire                          step,
    input  vfd_pkg::byte_word_t          held_word,
    output vfd_pkg::decode_out_t         dec_out
);
    import vfd_pkg::*;

    logic [FmtW-1:0]   format_reg;
    logic [LeftW-1:0]  bytes_left_reg;
    logic [LeftW-1:0]  bytes_left_next;
    logic [MagW-1:0]   mag_reg;
    logic [MagW-1:0]   mag_next;
    logic              sign_reg;
    logic              sign_next;

    logic [ByteW-1:0]  b;
    logic [LeftW-1:0]  left_upd;
    logic [MagW-1:0]   mag_upd;
    logic              sign_upd;
    logic              done;
    logic [ValueW-1:0] mag_ext;

    assign b = held_word.data_byte;

    // Split the first byte by format, or shift in a following byte
    always_comb
    begin
        left_upd = bytes_left_reg;
        mag_upd  = mag_reg;
        sign_upd = sign_reg;
        if (bytes_left_reg == '0)
        begin
            case (format_reg)
                FMT_U16:
                begin
                    left_upd = {{(LeftW-1){1'b0}}, (b & Bit7Mask) != '0};
                    sign_upd = 1'b0;
                    mag_upd  = {{(MagW-ByteW){1'b0}}, b & Low7Mask};
                end
                FMT_S16:
                begin
                    left_upd = {{(LeftW-1){1'b0}}, (b & Bit7Mask) != '0};
                    sign_upd = (b & Bit6Mask) != '0;
                    mag_upd  = {{(MagW-ByteW){1'b0}}, b & Low6Mask};
                end
                FMT_U32:
                begin
                    left_upd = {1'b0, b[7:6]};
                    sign_upd = 1'b0;
                    mag_upd  = {{(MagW-ByteW){1'b0}}, b & Low6Mask};
                end
                FMT_S32:
                begin
                    left_upd = {1'b0, b[7:6]};
                    sign_upd = (b & Bit5Mask) != '0;
                    mag_upd  = {{(MagW-ByteW){1'b0}}, b & Low5Mask};
                end
                default:
                begin
                    left_upd = b[7:5];
                    sign_upd = 1'b0;
                    mag_upd  = {{(MagW-ByteW){1'b0}}, b & Low5Mask};
                end
            endcase
        end
        else
        begin
            mag_upd  = {mag_reg[MagW-ByteW-1:0], b};
            left_upd = bytes_left_reg - LeftW'(1);
        end
    end

    assign done    = (left_upd == '0);
    assign mag_ext = {1'b0, mag_upd};

    // Form the result: negate signed values, zero on truncation
    always_comb
    begin
        dec_out.has_result = step && (done || held_word.buffer_end);
        if (done)
        begin
            dec_out.word.decoded_value = sign_upd ? -mag_ext : mag_ext;
            dec_out.word.decode_status = StatusComplete;
        end
        else
        begin
            dec_out.word.decoded_value = '0;
            dec_out.word.decode_status = StatusTruncated;
        end
    end

    // Clear the state once a result leaves, else advance it
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        mag_next        = mag_reg;
        sign_next       = sign_reg;
        if (step)
        begin
            if (done || held_word.buffer_end)
            begin
                bytes_left_next = '0;
                mag_next        = '0;
                sign_next       = 1'b0;
            end
            else
            begin
                bytes_left_next = left_upd;
                mag_next        = mag_upd;
                sign_next       = sign_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg     <= FormatReset;
            bytes_left_reg <= '0;
            mag_reg        <= '0;
            sign_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                format_reg <= cfg_data;
            bytes_left_reg <= bytes_left_next;
            mag_reg        <= mag_next;
            sign_reg       <= sign_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vfd_out_stage.sv @@
`default_nettype none

module vfd_out_stage (
    input  wire                   clk,
    input  wire                   rst_n,
    input  vfd_pkg::decode_out_t  dec_out,
    output logic                  slot_free,
    output logic                  result_valid,
    input  wire                   result_ready,
    output vfd_pkg::result_word_t result_word
);
    import vfd_pkg::*;

    logic         result_valid_reg;
    logic         result_valid_next;
    result_word_t result_word_reg;

    // The slot frees when empty or when its word is taken this cycle
    assign slot_free    = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    always_comb
    begin
        if (slot_free)
            result_valid_next = dec_out.has_result;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // Load a fresh result only into a free slot
    always_ff @(posedge clk)
    begin
        if (slot_free && dec_out.has_result)
            result_word_reg <= dec_out.word;
    end

endmodule

`default_nettype wire

@@ rtl/varint_field_decoder_unit.sv @@
// Path: a byte accepted into the input register is decoded combinationally and
// its result word is loaded into the result register that drives the output.
// Throughput: one byte per cycle; the input register and the result
// register form a two-deep pipeline stalled only by a held result.
// Reset: rst_n asynchronous, active low; clears both stages, the decode
// state and the format register (u16).
`default_nettype none

module varint_field_decoder_unit (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   byte_valid,
    output logic                  byte_ready,
    input  vfd_pkg::byte_word_t   byte_word,
    output logic                  result_valid,
    input  wire                   result_ready,
    output vfd_pkg::result_word_t result_word,
    input  wire                   cfg_we,
    input  wire  [vfd_pkg::FmtW-1:0] cfg_data
);
    import vfd_pkg::*;

    logic        slot_free;
    logic        step;
    byte_word_t  held_word;
    decode_out_t dec_out;

    vfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word),
        .slot_free  (slot_free),
        .step       (step),
        .held_word  (held_word)
    );

    vfd_decode_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .step      (step),
        .held_word (held_word),
        .dec_out   (dec_out)
    );

    vfd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .dec_out      (dec_out),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire

@@ rtl/vfd_checker.sv @@
`default_nettype none

`include "varint_field_decoder_unit_macros.svh"

module vfd_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   byte_ready,
    input wire                   result_valid,
    input wire                   result_ready,
    input vfd_pkg::result_word_t result_word
);
    import vfd_pkg::*;

    // A stalled result word stays put
    `VFD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result_word))

    // A truncation word carries a zero value
    `VFD_ASSERT_NOW(a_trunc_zero, result_valid && result_word.decode_status == StatusTruncated,
        result_word.decoded_value == '0)

    // Input back-pressure only comes from a held result
    `VFD_ASSERT_NOW(a_ready_cause, !byte_ready, result_valid && !result_ready)

endmodule

bind varint_field_decoder_unit vfd_checker u_vfd_checker (.*);

`default_nettype wire

@@ tb/tb_varint_field_decoder_unit.sv @@
module tb_varint_field_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vfd_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int RandomBytes = 660;
    localparam int DrainWait   = 4;
    localparam int ReportLimit = 10;

    // Alias code that decodes as u64
    localparam logic [FmtW-1:0] FmtAliasU64 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic byte_valid;
    logic byte_ready;
    byte_word_t byte_word;
    logic result_valid;
    logic result_ready;
    result_word_t result_word;
    logic cfg_we;
    logic [FmtW-1:0] cfg_data;

    // Decoder state as the bench sees it
    logic [FmtW-1:0]  model_fmt;
    logic [LeftW-1:0] model_left;
    logic [MagW-1:0]  model_mag;
    bit               model_neg;

    result_word_t pending_results[$];

    int  cycle_count;
    int  mismatches;
    int  bytes_taken;
    int  results_seen;
    int  truncations;
    int  format_writes;
    bit  src_idle_on;
    bit  sink_idle_on;
    int  sink_hold;
    int  sink_stall;

    varint_field_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Count of bytes that follow a header byte in the given format
    function automatic logic [LeftW-1:0] follow_count(input logic [FmtW-1:0] fmt,
                                                      input logic [ByteW-1:0] b);
        case (fmt)
            FMT_U16, FMT_S16: return {2'b00, b[7]};
            FMT_U32, FMT_S32: return {1'b0, b[7:6]};
            default:          return b[7:5];
        endcase
    endfunction

    // Advance the decoder state by one byte; flag and fill a result when one is due
    task automatic decode_byte(input byte_word_t w, output bit produced,
                               output result_word_t res);
        logic [ByteW-1:0]  b;
        logic [ValueW-1:0] v;
        b = w.data_byte;
        produced = 1'b0;
        res = '0;
        if (model_left == 0)
        begin
            model_left = follow_count(model_fmt, b);
            case (model_fmt)
                FMT_U16:
                begin
                    model_neg = 1'b0;
                    model_mag = MagW'(b[6:0]);
                end
                FMT_S16:
                begin
                    model_neg = b[6];
                    model_mag = MagW'(b[5:0]);
                end
                FMT_U32:
                begin
                    model_neg = 1'b0;
                    model_mag = MagW'(b[5:0]);
                end
                FMT_S32:
                begin
                    model_neg = b[5];
                    model_mag = MagW'(b[4:0]);
                end
                default:
                begin
                    model_neg = 1'b0;
                    model_mag = MagW'(b[4:0]);
                end
            endcase
        end
        else
        begin
            model_mag = {model_mag[MagW-ByteW-1:0], b};
            model_left = model_left - 1'b1;
        end
        if (model_left == 0)
        begin
            v = {1'b0, model_mag};
            if (model_neg)
                v = -v;
            res.decoded_value = v;
            res.decode_status = StatusComplete;
            produced = 1'b1;
        end
        else if (w.buffer_end)
        begin
            res.decoded_value = '0;
            res.decode_status = StatusTruncated;
            produced = 1'b1;
        end
        if (produced)
        begin
            model_left = '0;
            model_mag = '0;
            model_neg = 1'b0;
        end
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= ReportLimit)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Compare one result word with the oldest expectation
    task automatic check_result(input result_word_t got);
        result_word_t want;
        if (pending_results.size() == 0)
        begin
            report_error($sformatf("unexpected result: value %h status %0d",
                                   got.decoded_value, got.decode_status));
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (want.decode_status == StatusTruncated)
            truncations++;
        if (got.decoded_value !== want.decoded_value)
            report_error($sformatf("result %0d decoded_value: expected %h, got %h",
                                   results_seen, want.decoded_value, got.decoded_value));
        if (got.decode_status !== want.decode_status)
            report_error($sformatf("result %0d decode_status: expected %0d, got %0d",
                                   results_seen, want.decode_status, got.decode_status));
    endtask

    // Watch both handshakes at the rising edge
    always @(posedge clk)
    begin : watch
        bit           produced;
        result_word_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
                check_result(result_word);
            if (byte_valid && byte_ready)
            begin
                bytes_taken++;
                decode_byte(byte_word, produced, want);
                if (produced)
                    pending_results.push_back(want);
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ByteW-1:0] random_byte();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            return 8'hFF;
        if (pick < 5)
            return 8'h00;
        return ByteW'($urandom_range(0, 255));
    endfunction

    // Result side: long hold-offs on request, random stalls otherwise
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            result_ready <= 1'b0;
            sink_hold--;
        end
        else if (sink_stall > 0)
        begin
            result_ready <= 1'b0;
            sink_stall--;
        end
        else
        begin
            result_ready <= 1'b1;
            if (sink_idle_on)
                sink_stall = pick_gap();
        end
    end

    // Offer one word and hold it until taken; called and returns at a falling edge
    task automatic send_byte(input logic [ByteW-1:0] data, input bit last);
        byte_word_t w;
        int gap;
        w.data_byte = data;
        w.buffer_end = last;
        byte_word <= w;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        @(negedge clk);
        gap = src_idle_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic stop_bytes();
        byte_valid <= 1'b0;
    endtask

    // Pause input until every expected word is back and the pipeline is quiet
    task automatic drain();
        stop_bytes();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DrainWait) @(negedge clk);
    endtask

    task automatic write_format(input logic [FmtW-1:0] fmt);
        drain();
        cfg_data <= fmt;
        cfg_we <= 1'b1;
        model_fmt = fmt;
        format_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One encoded value with random content; now and then cut short by a buffer end
    task automatic send_value(inout int sent);
        logic [ByteW-1:0] b;
        int follow;
        int cut;
        b = random_byte();
        follow = int'(follow_count(model_fmt, b));
        cut = -1;
        if (follow != 0 && $urandom_range(0, 9) == 0)
            cut = $urandom_range(0, follow - 1);
        for (int i = 0; i <= follow; i++)
        begin
            sent++;
            if (i == cut)
            begin
                send_byte(b, 1'b1);
                break;
            end
            send_byte(b, i == follow && $urandom_range(0, 3) == 0);
            b = random_byte();
        end
    endtask

    task automatic test_directed_formats();
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        // u16: largest single byte, largest two-byte value ending the buffer
        write_format(FMT_U16);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // s16: most negative value, then negative zero
        write_format(FMT_S16);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h40, 1'b0);
        // u32 and s32 at full length and all ones
        write_format(FMT_U32);
        repeat (4) send_byte(8'hFF, 1'b0);
        write_format(FMT_S32);
        repeat (4) send_byte(8'hFF, 1'b0);
        // u64 full 61-bit magnitude, then a buffer end mid-value
        write_format(FMT_U64);
        repeat (8) send_byte(8'hFF, 1'b0);
        send_byte(8'h20, 1'b1);
        // unused format code behaves as u64
        write_format(FmtAliasU64);
        send_byte(8'h00, 1'b0);
        // switch format while a u32 value is open
        write_format(FMT_U32);
        send_byte(8'h40, 1'b0);
        write_format(FMT_U16);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_backpressure();
        write_format(FMT_U16);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        // hold the result side so the pipeline fills and stalls its input
        sink_hold = 250;
        repeat (40) send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'($urandom_range(0, 1)));
        drain();
    endtask

    task automatic test_random_streams();
        int sent;
        int nvals;
        sent = 0;
        while (sent < RandomBytes)
        begin
            write_format(FmtW'($urandom_range(0, 7)));
            src_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            nvals = $urandom_range(10, 40);
            repeat (nvals)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_byte(random_byte(), 1'($urandom_range(0, 1)));
                    sent++;
                end
                else
                    send_value(sent);
            end
            // leave a value open so the next format write lands mid-value
            if ($urandom_range(0, 2) == 0)
            begin
                send_byte(random_byte() | Bit7Mask, 1'b0);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_word = '0;
        result_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        model_fmt = FormatReset;
        model_left = '0;
        model_mag = '0;
        model_neg = 1'b0;
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        sink_hold = 0;
        sink_stall = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_formats();
        test_backpressure();
        test_random_streams();

        drain();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        $display("Decoded %0d bytes into %0d results, %0d of them truncated,",
                 bytes_taken, results_seen, truncations);
        $display("over %0d format writes with random stalls and a long result hold-off.",
                 format_writes);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
